>>> rtl/core/ffsa_pkg.sv
// Shared types, constants and codes of the first-fit segment allocator.
`timescale 1ns / 1ps
package ffsa_pkg;

    // Table sizes and address width.
    localparam int FREE_SLOTS = 64;
    localparam int USED_SLOTS = 64;
    localparam int ADDR_W     = 32;

    localparam int FIDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int UIDX_W = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
    localparam int FCNT_W = $clog2(FREE_SLOTS + 1);
    localparam int UCNT_W = $clog2(USED_SLOTS + 1);

    // Field widths of one request and one result.
    localparam int FUNC_W   = 2;
    localparam int SIZE_W   = 32;
    localparam int ALIGN_W  = 17;
    localparam int OFFSET_W = 32;
    localparam int STATUS_W = 2;

    // Request packing: req_size, req_align, free_offset from bit 0 up.
    localparam int SIZE_LSB   = 0;
    localparam int ALIGN_LSB  = SIZE_LSB + SIZE_W;
    localparam int OFFSET_LSB = ALIGN_LSB + ALIGN_W;
    localparam int IN_BITS    = OFFSET_LSB + OFFSET_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OFFSET_W + 7) / 8) * 8;

    // Remainder unit: one dividend bit per cycle.
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Request kinds.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_FIT    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // One table entry; free entries leave seg_aln unused.
    typedef struct packed {
        logic [ADDR_W-1:0] seg_start;
        logic [ADDR_W-1:0] seg_aln;
        logic [ADDR_W-1:0] seg_end;
    } t_seg;

    localparam t_seg SEG_ZERO = '{default: '0};

    // Operation broadcast to every cell of one chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SCAN,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_seg     wdata;
    } t_cell_ctl;

    // Where a cell sits relative to the addressed position.
    typedef struct packed {
        logic hit;
        logic above;
    } t_pos_cmp;

endpackage

>>> rtl/core/ffsa_cell.sv
// One table cell: a stored entry plus a scan copy that shifts toward the head.
`timescale 1ns / 1ps
module ffsa_cell (
    input  logic               i_clk,
    input  ffsa_pkg::t_cell_ctl i_ctl,
    input  ffsa_pkg::t_pos_cmp  i_cmp,
    input  ffsa_pkg::t_seg      i_prev_main,
    input  ffsa_pkg::t_seg      i_next_main,
    input  ffsa_pkg::t_seg      i_next_shadow,
    output ffsa_pkg::t_seg      o_main,
    output ffsa_pkg::t_seg      o_shadow
);
    import ffsa_pkg::*;

    t_seg r_main;
    t_seg r_shadow;

    // Entry update and scan shifting.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CELL_LOAD: begin
                r_shadow <= r_main;
            end
            CELL_SCAN: begin
                r_shadow <= i_next_shadow;
            end
            CELL_WRITE: begin
                if (i_cmp.hit) begin
                    r_main <= i_ctl.wdata;
                end
            end
            CELL_INSERT: begin
                if (i_cmp.hit) begin
                    r_main <= i_ctl.wdata;
                end else if (i_cmp.above) begin
                    r_main <= i_prev_main;
                end
            end
            CELL_REMOVE: begin
                if (i_cmp.hit || i_cmp.above) begin
                    r_main <= i_next_main;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_main   = r_main;
    assign o_shadow = r_shadow;

endmodule

>>> rtl/core/ffsa_div.sv
// Restoring remainder unit: segment start modulo alignment, one bit per cycle.
`timescale 1ns / 1ps
module ffsa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ffsa_pkg::ADDR_W-1:0]   i_dividend,
    input  logic [ffsa_pkg::ALIGN_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [ffsa_pkg::ALIGN_W-1:0]  o_rem
);
    import ffsa_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ADDR_W-1:0]    r_dvd;
    logic [ALIGN_W-1:0]   r_dsr;
    logic [ALIGN_W-1:0]   r_rem;
    logic [ALIGN_W:0]     w_trial;
    logic [ALIGN_W:0]     w_diff;

    // Bring down the next dividend bit and try the subtraction.
    assign w_trial = {r_rem, r_dvd[ADDR_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_dvd  <= i_dividend;
            r_dsr  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ADDR_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dsr}) begin
                r_rem <= w_diff[ALIGN_W-1:0];
            end else begin
                r_rem <= w_trial[ALIGN_W-1:0];
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/first_fit_segment_allocator_unit.sv
// Top level of the first-fit segment allocator: sequencer, two cell chains, remainder unit.
//
//  channel   direction  signals                                  contents
//  s_axis    in         s_axis_tvalid/tready/tdata/tuser         request
//  m_axis    out        m_axis_tvalid/tready/tdata/tuser         result
//  cfg       in         i_cfg_valid/o_cfg_ready/i_cfg_data       total_size register
//
// Allocate: each free entry large enough gets its alignment remainder from the remainder
// unit, one bit per cycle, and each smaller one is passed; then the segment is shrunk,
// used entries are passed up to the insertion point, the new entry is inserted and the
// result is posted. Free: used entries are searched and free entries passed, then the
// tables are updated and the result posted, with a further free entry removal when the
// span joins both neighbors. Clear, reset and every configuration write restore the
// single free segment before the block takes a request.
// A waiting result holds the block only once the next result is ready to post.
`timescale 1ns / 1ps
module first_fit_segment_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request: req_size, req_align, free_offset from bit 0 up.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ffsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Request kind: func.
    input  logic [ffsa_pkg::FUNC_W-1:0]         s_axis_tuser,
    // Result: alloc_offset.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ffsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Result kind: status.
    output logic [ffsa_pkg::STATUS_W-1:0]       m_axis_tuser,
    // Configuration write: total_size.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ffsa_pkg::ADDR_W-1:0]         i_cfg_data
);
    import ffsa_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_A_FSCAN,
        ST_A_DIV,
        ST_A_FUPD,
        ST_A_USCAN,
        ST_F_USCAN,
        ST_F_FSCAN,
        ST_F_UPD,
        ST_F_FREM,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [FCNT_W-1:0]   r_fcnt;
    logic [UCNT_W-1:0]   r_ucnt;
    logic [FCNT_W-1:0]   r_idx;
    logic [UCNT_W-1:0]   r_uidx;
    logic [ADDR_W-1:0]   r_total;
    logic [SIZE_W-1:0]   r_size;
    logic [ALIGN_W-1:0]  r_align;
    logic [OFFSET_W-1:0] r_off;
    logic [ALIGN_W-1:0]  r_pad;
    logic [ADDR_W-1:0]   r_b;
    logic [ADDR_W-1:0]   r_e;
    logic [ADDR_W-1:0]   r_p;
    logic [ADDR_W-1:0]   r_ne;
    t_seg                r_prev;
    t_seg                r_cur;
    logic                r_mp;
    logic                r_mn;
    logic [OFFSET_W-1:0] r_res_off;
    logic [STATUS_W-1:0] r_res_st;
    logic                r_out_valid;
    logic [OFFSET_W-1:0] r_out_off;
    logic [STATUS_W-1:0] r_out_st;

    t_cell_ctl   c_fctl;
    t_cell_ctl   c_uctl;
    logic [FIDX_W-1:0] c_fpos;
    logic [UIDX_W-1:0] c_upos;

    t_seg w_fmain   [FREE_SLOTS];
    t_seg w_fshadow [FREE_SLOTS];
    t_seg w_umain   [USED_SLOTS];
    t_seg w_ushadow [USED_SLOTS];
    t_seg w_fhead;
    t_seg w_uhead;

    logic                c_s_acc;
    logic                c_cfg_acc;
    logic [ADDR_W-1:0]   c_space;
    logic                c_size_fits;
    logic [ALIGN_W-1:0]  c_align;
    logic [ALIGN_W-1:0]  c_pad;
    logic [ADDR_W-1:0]   c_slack;
    logic                c_pad_miss;
    logic [ADDR_W-1:0]   c_p;
    logic [ADDR_W-1:0]   c_ne;
    logic                c_used_full;
    logic                c_f_end;
    logic                c_u_end;
    logic                c_ins_here;
    logic                c_fstop;
    logic                c_mp;
    logic                c_mn;
    logic                c_div_start;
    logic                w_div_done;
    logic [ALIGN_W-1:0]  w_div_rem;

    // Handshakes: one request at a time, configuration only while idle.
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign c_s_acc       = s_axis_tvalid && s_axis_tready;
    assign c_cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_off);
    assign m_axis_tuser  = r_out_st;

    assign w_fhead = w_fshadow[0];
    assign w_uhead = w_ushadow[0];

    // Fit test of the free entry at the scan head.
    assign c_space     = (w_fhead.seg_end >= w_fhead.seg_start)
                         ? (w_fhead.seg_end - w_fhead.seg_start) : '0;
    assign c_size_fits = (r_size <= c_space);
    assign c_align     = (r_align == '0) ? ALIGN_W'(1) : r_align;
    assign c_pad       = (w_div_rem == '0) ? '0 : (c_align - w_div_rem);
    assign c_slack     = c_space - r_size;
    assign c_pad_miss  = (ADDR_W'(c_pad) > c_slack);
    assign c_p         = w_fhead.seg_start + ADDR_W'(r_pad);
    assign c_ne        = c_p + r_size;
    assign c_used_full = (r_ucnt >= UCNT_W'(USED_SLOTS));
    assign c_f_end     = (r_idx >= r_fcnt);
    assign c_u_end     = (r_uidx >= r_ucnt);
    assign c_ins_here  = c_u_end || (w_uhead.seg_start >= r_b);
    assign c_div_start = (r_state == ST_A_FSCAN) && !c_used_full && !c_f_end && c_size_fits;

    // Neighbor test for a freed span.
    assign c_fstop = c_f_end || (w_fhead.seg_start >= r_b);
    assign c_mp    = (r_idx != '0) && (r_prev.seg_end == r_b);
    assign c_mn    = !c_f_end && (w_fhead.seg_start == r_e);

    // Chain operations issued by the sequencer.
    always_comb begin
        c_fctl.op    = CELL_HOLD;
        c_fctl.wdata = SEG_ZERO;
        c_uctl.op    = CELL_HOLD;
        c_uctl.wdata = SEG_ZERO;
        c_fpos       = r_idx[FIDX_W-1:0];
        c_upos       = r_uidx[UIDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                c_fctl.op = CELL_LOAD;
                c_uctl.op = CELL_LOAD;
            end
            ST_INIT, ST_CLR: begin
                c_fctl.op = CELL_WRITE;
                c_fpos    = '0;
                c_fctl.wdata.seg_end = r_total;
            end
            ST_A_FSCAN: begin
                if (!c_used_full && !c_f_end && !c_size_fits) begin
                    c_fctl.op = CELL_SCAN;
                end
            end
            ST_A_DIV: begin
                if (w_div_done && c_pad_miss) begin
                    c_fctl.op = CELL_SCAN;
                end
            end
            ST_A_FUPD: begin
                if (c_ne == w_fhead.seg_end) begin
                    c_fctl.op = CELL_REMOVE;
                end else begin
                    c_fctl.op              = CELL_WRITE;
                    c_fctl.wdata.seg_start = c_ne;
                    c_fctl.wdata.seg_end   = w_fhead.seg_end;
                end
            end
            ST_A_USCAN: begin
                if (c_ins_here) begin
                    c_uctl.op              = CELL_INSERT;
                    c_uctl.wdata.seg_start = r_b;
                    c_uctl.wdata.seg_aln   = r_p;
                    c_uctl.wdata.seg_end   = r_ne;
                end else begin
                    c_uctl.op = CELL_SCAN;
                end
            end
            ST_F_USCAN: begin
                if (!c_u_end && (w_uhead.seg_aln != r_off)) begin
                    c_uctl.op = CELL_SCAN;
                end
            end
            ST_F_FSCAN: begin
                if (!c_fstop) begin
                    c_fctl.op = CELL_SCAN;
                end
            end
            ST_F_UPD: begin
                c_uctl.op = CELL_REMOVE;
                if (r_mp) begin
                    c_fctl.op              = CELL_WRITE;
                    c_fpos                 = r_idx[FIDX_W-1:0] - 1'b1;
                    c_fctl.wdata.seg_start = r_prev.seg_start;
                    c_fctl.wdata.seg_end   = r_mn ? r_cur.seg_end : r_e;
                end else if (r_mn) begin
                    c_fctl.op              = CELL_WRITE;
                    c_fctl.wdata.seg_start = r_b;
                    c_fctl.wdata.seg_end   = r_cur.seg_end;
                end else begin
                    c_fctl.op              = CELL_INSERT;
                    c_fctl.wdata.seg_start = r_b;
                    c_fctl.wdata.seg_end   = r_e;
                end
            end
            ST_F_FREM: begin
                c_fctl.op = CELL_REMOVE;
            end
            default: begin
            end
        endcase
    end

    // Free table chain.
    for (genvar j = 0; j < FREE_SLOTS; j++) begin : g_free
        t_pos_cmp w_cmp;
        t_seg     w_prev;
        t_seg     w_next;
        t_seg     w_next_sh;
        assign w_cmp.hit   = (c_fpos == FIDX_W'(j));
        assign w_cmp.above = (FIDX_W'(j) > c_fpos);
        if (j == 0) begin : g_first
            assign w_prev = SEG_ZERO;
        end else begin : g_mid
            assign w_prev = w_fmain[j-1];
        end
        if (j == FREE_SLOTS - 1) begin : g_last
            assign w_next    = SEG_ZERO;
            assign w_next_sh = SEG_ZERO;
        end else begin : g_inner
            assign w_next    = w_fmain[j+1];
            assign w_next_sh = w_fshadow[j+1];
        end
        ffsa_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (c_fctl),
            .i_cmp         (w_cmp),
            .i_prev_main   (w_prev),
            .i_next_main   (w_next),
            .i_next_shadow (w_next_sh),
            .o_main        (w_fmain[j]),
            .o_shadow      (w_fshadow[j])
        );
    end

    // Used table chain.
    for (genvar j = 0; j < USED_SLOTS; j++) begin : g_used
        t_pos_cmp w_cmp;
        t_seg     w_prev;
        t_seg     w_next;
        t_seg     w_next_sh;
        assign w_cmp.hit   = (c_upos == UIDX_W'(j));
        assign w_cmp.above = (UIDX_W'(j) > c_upos);
        if (j == 0) begin : g_first
            assign w_prev = SEG_ZERO;
        end else begin : g_mid
            assign w_prev = w_umain[j-1];
        end
        if (j == USED_SLOTS - 1) begin : g_last
            assign w_next    = SEG_ZERO;
            assign w_next_sh = SEG_ZERO;
        end else begin : g_inner
            assign w_next    = w_umain[j+1];
            assign w_next_sh = w_ushadow[j+1];
        end
        ffsa_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (c_uctl),
            .i_cmp         (w_cmp),
            .i_prev_main   (w_prev),
            .i_next_main   (w_next),
            .i_next_shadow (w_next_sh),
            .o_main        (w_umain[j]),
            .o_shadow      (w_ushadow[j])
        );
    end

    // Alignment remainder of the candidate segment start.
    ffsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_div_start),
        .i_dividend (w_fhead.seg_start),
        .i_divisor  (c_align),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // Sequencer, table counts and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_fcnt      <= FCNT_W'(1);
            r_ucnt      <= '0;
            r_idx       <= '0;
            r_uidx      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_INIT: begin
                    r_fcnt  <= FCNT_W'(1);
                    r_ucnt  <= '0;
                    r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    r_idx  <= '0;
                    r_uidx <= '0;
                    if (c_cfg_acc) begin
                        r_total <= i_cfg_data;
                        r_state <= ST_INIT;
                    end else if (c_s_acc) begin
                        r_size    <= s_axis_tdata[SIZE_LSB +: SIZE_W];
                        r_align   <= s_axis_tdata[ALIGN_LSB +: ALIGN_W];
                        r_off     <= s_axis_tdata[OFFSET_LSB +: OFFSET_W];
                        r_res_off <= '0;
                        r_res_st  <= STAT_OK;
                        case (s_axis_tuser)
                            FUNC_ALLOC: r_state <= ST_A_FSCAN;
                            FUNC_FREE:  r_state <= ST_F_USCAN;
                            FUNC_CLEAR: r_state <= ST_CLR;
                            default:    r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_CLR: begin
                    r_fcnt  <= FCNT_W'(1);
                    r_ucnt  <= '0;
                    r_state <= ST_DONE;
                end
                ST_A_FSCAN: begin
                    if (c_used_full) begin
                        r_res_st <= STAT_FULL;
                        r_state  <= ST_DONE;
                    end else if (c_f_end) begin
                        r_res_st <= STAT_NO_FIT;
                        r_state  <= ST_DONE;
                    end else if (!c_size_fits) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= ST_A_DIV;
                    end
                end
                ST_A_DIV: begin
                    if (w_div_done) begin
                        if (c_pad_miss) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_A_FSCAN;
                        end else begin
                            r_pad   <= c_pad;
                            r_b     <= w_fhead.seg_start;
                            r_state <= ST_A_FUPD;
                        end
                    end
                end
                ST_A_FUPD: begin
                    r_p  <= c_p;
                    r_ne <= c_ne;
                    if (c_ne == w_fhead.seg_end) begin
                        r_fcnt <= r_fcnt - 1'b1;
                    end
                    r_state <= ST_A_USCAN;
                end
                ST_A_USCAN: begin
                    if (c_ins_here) begin
                        r_ucnt    <= r_ucnt + 1'b1;
                        r_res_off <= r_p;
                        r_state   <= ST_DONE;
                    end else begin
                        r_uidx <= r_uidx + 1'b1;
                    end
                end
                ST_F_USCAN: begin
                    if (c_u_end) begin
                        r_res_st <= STAT_NOT_FOUND;
                        r_state  <= ST_DONE;
                    end else if (w_uhead.seg_aln == r_off) begin
                        r_b     <= w_uhead.seg_start;
                        r_e     <= w_uhead.seg_end;
                        r_state <= ST_F_FSCAN;
                    end else begin
                        r_uidx <= r_uidx + 1'b1;
                    end
                end
                ST_F_FSCAN: begin
                    if (c_fstop) begin
                        r_cur <= w_fhead;
                        r_mp  <= c_mp;
                        r_mn  <= c_mn;
                        if (!c_mp && !c_mn && (r_fcnt >= FCNT_W'(FREE_SLOTS))) begin
                            r_res_st <= STAT_FULL;
                            r_state  <= ST_DONE;
                        end else begin
                            r_state <= ST_F_UPD;
                        end
                    end else begin
                        r_prev <= w_fhead;
                        r_idx  <= r_idx + 1'b1;
                    end
                end
                ST_F_UPD: begin
                    r_ucnt <= r_ucnt - 1'b1;
                    if (r_mp && r_mn) begin
                        r_state <= ST_F_FREM;
                    end else begin
                        if (!r_mp && !r_mn) begin
                            r_fcnt <= r_fcnt + 1'b1;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_F_FREM: begin
                    r_fcnt  <= r_fcnt - 1'b1;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_off   <= r_res_off;
                        r_out_st    <= r_res_st;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_INIT;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/ffsa_checker.sv
// Port-level checks of the first-fit segment allocator and their attachment.
`timescale 1ns / 1ps
module ffsa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [ffsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [ffsa_pkg::STATUS_W-1:0]       m_axis_tuser,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready
);
    import ffsa_pkg::*;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A result with a failure status reports a zero offset.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata == '0)
        else $error("nonzero offset with failure status");

    // Requests are worked one at a time.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !o_cfg_ready)
        else $error("second transaction taken while busy");

    // A configuration write restores the table before the next request.
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !s_axis_tready)
        else $error("request taken during table restore");

endmodule

bind first_fit_segment_allocator_unit ffsa_checker u_ffsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);
